>>> rtl/core/sckg_pkg.sv
// Shared types, constants and step functions for the SPH cubic kernel pipeline.
// Used by every module in rtl/core; depends on nothing.
package sckg_pkg;

    localparam int FRAC = 16;

    localparam logic [64:0] ONE_Q = 65'(1) << FRAC;
    localparam logic [64:0] TWO_Q = 65'(2) << FRAC;

    localparam int TW  = FRAC + 2;   // t = 2 - q
    localparam int SW  = FRAC + 1;   // s = 1 - q
    localparam int T2W = FRAC + 3;
    localparam int S2W = FRAC + 1;
    localparam int T3W = FRAC + 4;
    localparam int S3W = FRAC + 1;
    localparam int PW  = FRAC + 4;   // clipped polynomial
    localparam int AW  = FRAC + 4;   // gradient polynomial magnitude
    localparam int MAGW = 65;

    localparam int SQ_STAGES  = 17;
    localparam int DIV_STAGES = 17;

    localparam logic [31:0] INV_RESET   = 32'd65536;
    localparam logic [31:0] SCALE_RESET = 32'd26075;

    // register index, taken from paddr[2]
    localparam logic REG_INV   = 1'b0;
    localparam logic REG_SCALE = 1'b1;

    typedef struct packed {
        logic [31:0] inv;
        logic [31:0] alpha;
    } t_cfg;

    typedef struct packed {
        logic [31:0] adx;
        logic [31:0] ady;
        logic        xneg;
        logic        yneg;
    } t_geo;

    typedef struct packed {
        t_geo            geo;
        logic [32:0]     r;
        logic            support;
        logic [31:0]     w;
        logic            w_sat;
        logic [MAGW-1:0] mag;
        logic            gneg;
    } t_kern;

    typedef struct packed {
        t_kern       k;
        logic [32:0] ux;
        logic [32:0] uy;
    } t_divo;

    typedef struct packed {
        logic [35:0] rem;
        logic [32:0] root;
    } t_sq;

    typedef struct packed {
        logic [33:0] rem;
        logic [32:0] quo;
    } t_dv;

    typedef struct packed {
        logic [31:0] val;
        logic        flag;
    } t_sat;

    // one digit of the restoring square root
    function automatic t_sq sqrt_step(input logic [35:0] rem, input logic [32:0] root,
                                      input logic [1:0] pair);
        t_sq         res;
        logic [35:0] r2;
        logic [35:0] trial;
        r2       = {rem[33:0], pair};
        trial    = {1'b0, root, 2'b01};
        res.root = {root[31:0], 1'b0};
        if (r2 >= trial) begin
            res.rem     = r2 - trial;
            res.root[0] = 1'b1;
        end else begin
            res.rem = r2;
        end
        return res;
    endfunction

    // one quotient bit of the restoring divider
    function automatic t_dv div_step(input logic [33:0] rem, input logic [32:0] dvs,
                                     input logic shift, input logic [32:0] quo);
        t_dv         res;
        logic [33:0] r2;
        r2 = shift ? {rem[32:0], 1'b0} : rem;
        if (r2 >= {1'b0, dvs}) begin
            res.rem = r2 - {1'b0, dvs};
            res.quo = {quo[31:0], 1'b1};
        end else begin
            res.rem = r2;
            res.quo = {quo[31:0], 1'b0};
        end
        return res;
    endfunction

    function automatic t_sat sat_grad(input logic [65:0] c, input logic neg);
        t_sat res;
        res.flag = 1'b0;
        if (!neg) begin
            if (c > 66'h7FFF_FFFF) begin
                res.val  = 32'h7FFF_FFFF;
                res.flag = 1'b1;
            end else begin
                res.val = c[31:0];
            end
        end else begin
            if (c > 66'h8000_0000) begin
                res.val  = 32'h8000_0000;
                res.flag = 1'b1;
            end else begin
                res.val = ~c[31:0] + 32'd1;
            end
        end
        return res;
    endfunction

endpackage

>>> rtl/core/sph_cubic_kernel_and_gradient.sv
// Top level of the 2D SPH cubic spline kernel and gradient pipeline.
// Depends on sckg_pkg, sckg_sqrt, sckg_kernel and sckg_div.
//
// Usage:
//   Slave stream (i_s_*) takes one particle pair per transaction: two 2D
//   positions in signed Q16.16. Master stream (o_m_*) returns one result per
//   pair, in order: weight, gradient x and y, in-support and saturated flags.
//   An APB port holds the reciprocal smoothing length (address 0) and the
//   kernel scale alpha (address 4); write them only while the pipe is empty.
//   From acceptance to the result, a pair passes the input and square stages,
//   17 square root stages, 8 kernel stages, 17 divider stages, the gradient
//   product stage and the output register.
//   Throughput is one pair per cycle unless the output stalls; every stage holds one pair.
//   When the receiver holds i_m_tready low with a result waiting, the whole
//   pipe freezes and o_s_tready drops; nothing is lost or repeated. Bubbles
//   move forward while the output register is empty.
//   Reset (synchronous, active low) clears all valid bits and loads the
//   register defaults; o_s_tready stays low during reset and the pipe accepts
//   a pair on the next cycle.
module sph_cubic_kernel_and_gradient (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // point_a_x, point_a_y, point_b_x, point_b_y
    // master stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,   // weight, gradient_x, gradient_y, in_support,
                                      // saturated, zero fill
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import sckg_pkg::*;

    logic        en;
    logic [31:0] r_inv;
    logic [31:0] r_alpha;
    t_cfg        cfg;

    // input and square stages
    logic        r_v0;
    t_geo        r_geo0;
    logic        r_v1;
    t_geo        r_geo1;
    logic [63:0] r_sx1;
    logic [63:0] r_sy1;

    logic [32:0] n_dx;
    logic [32:0] n_dy;
    logic [32:0] n_adx;
    logic [32:0] n_ady;
    logic [64:0] n_sum;

    logic        sq_v;
    logic [32:0] sq_root;
    t_geo        sq_geo;
    logic        kn_v;
    t_kern       kn_k;
    logic        dv_v;
    t_divo       dv_res;

    // gradient product stage
    logic        r_vf;
    logic [65:0] r_hpx;
    logic [64:0] r_lpx;
    logic [65:0] r_hpy;
    logic [64:0] r_lpy;
    logic        r_negx;
    logic        r_negy;
    logic [31:0] r_wf;
    logic        r_wsatf;
    logic        r_supf;

    logic [32:0] n_ux;
    logic [32:0] n_uy;
    t_sat        n_gx;
    t_sat        n_gy;

    logic         r_out_v;
    logic [103:0] r_out_data;

    assign en         = !r_out_v || i_m_tready;
    assign o_s_tready = en && i_rst_n;
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign pready     = 1'b1;
    assign cfg.inv    = r_inv;
    assign cfg.alpha  = r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv   <= INV_RESET;
            r_alpha <= SCALE_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_INV:   r_inv   <= pwdata;
                REG_SCALE: r_alpha <= pwdata;
                default:   r_inv   <= r_inv;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_INV:   prdata = r_inv;
            REG_SCALE: prdata = r_alpha;
            default:   prdata = '0;
        endcase
    end

    always_comb begin
        n_dx  = {i_s_tdata[31], i_s_tdata[31:0]} - {i_s_tdata[95], i_s_tdata[95:64]};
        n_dy  = {i_s_tdata[63], i_s_tdata[63:32]} - {i_s_tdata[127], i_s_tdata[127:96]};
        n_adx = n_dx[32] ? -n_dx : n_dx;
        n_ady = n_dy[32] ? -n_dy : n_dy;
        n_sum = {1'b0, r_sx1} + {1'b0, r_sy1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_s_tvalid;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_geo0.adx  <= n_adx[31:0];
            r_geo0.ady  <= n_ady[31:0];
            r_geo0.xneg <= n_dx[32];
            r_geo0.yneg <= n_dy[32];
            r_geo1      <= r_geo0;
            r_sx1       <= 64'(r_geo0.adx) * 64'(r_geo0.adx);
            r_sy1       <= 64'(r_geo0.ady) * 64'(r_geo0.ady);
        end
    end

    sckg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v1),
        .i_rad   ({1'b0, n_sum}),
        .i_geo   (r_geo1),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_geo   (sq_geo)
    );

    sckg_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (cfg),
        .i_valid (sq_v),
        .i_r     (sq_root),
        .i_geo   (sq_geo),
        .o_valid (kn_v),
        .o_kern  (kn_k)
    );

    sckg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (kn_v),
        .i_kern  (kn_k),
        .o_valid (dv_v),
        .o_res   (dv_res)
    );

    // a zero axis difference gives a zero component
    assign n_ux = (dv_res.k.geo.adx == '0) ? '0 : dv_res.ux;
    assign n_uy = (dv_res.k.geo.ady == '0) ? '0 : dv_res.uy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_vf    <= dv_v;
            r_out_v <= r_vf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hpx   <= 66'(dv_res.k.mag[64:32]) * 66'(n_ux);
            r_lpx   <= 65'(dv_res.k.mag[31:0]) * 65'(n_ux);
            r_hpy   <= 66'(dv_res.k.mag[64:32]) * 66'(n_uy);
            r_lpy   <= 65'(dv_res.k.mag[31:0]) * 65'(n_uy);
            r_negx  <= dv_res.k.geo.xneg ^ dv_res.k.gneg;
            r_negy  <= dv_res.k.geo.yneg ^ dv_res.k.gneg;
            r_wf    <= dv_res.k.w;
            r_wsatf <= dv_res.k.w_sat;
            r_supf  <= dv_res.k.support;
        end
    end

    assign n_gx = sat_grad(r_hpx + 66'(r_lpx[64:32]), r_negx);
    assign n_gy = sat_grad(r_hpy + 66'(r_lpy[64:32]), r_negy);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {6'b000000, r_wsatf | n_gx.flag | n_gy.flag, r_supf,
                           n_gy.val, n_gx.val, r_wf};
        end
    end

    ast_no_support_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[96] |-> o_m_tdata[95:0] == 96'd0)
        else $error("result outside support carries nonzero values");

    ast_weight_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_m_tdata[31])
        else $error("negative kernel weight");

    ast_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("pipe blocked with an empty output register");

endmodule

>>> rtl/core/sckg_sqrt.sv
// Pipelined restoring square root, two result bits per stage but one in the last, 33-bit root.
// Depends on sckg_pkg; the geometry payload travels alongside.
module sckg_sqrt (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [65:0]   i_rad,
    input  sckg_pkg::t_geo i_geo,
    output logic          o_valid,
    output logic [32:0]   o_root,
    output sckg_pkg::t_geo o_geo
);
    import sckg_pkg::*;

    logic        r_v    [SQ_STAGES];
    logic [65:0] r_rad  [SQ_STAGES];
    logic [35:0] r_rem  [SQ_STAGES];
    logic [32:0] r_root [SQ_STAGES];
    t_geo        r_geo  [SQ_STAGES];

    for (genvar j = 0; j < SQ_STAGES; j++) begin : g_st
        logic        v_in;
        logic [65:0] rad_in;
        logic [35:0] rem_in;
        logic [32:0] root_in;
        t_geo        geo_in;
        t_sq         n_s0;
        t_sq         n_s1;

        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign geo_in  = i_geo;
        end else begin : g_next
            assign v_in    = r_v[j-1];
            assign rad_in  = r_rad[j-1];
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
            assign geo_in  = r_geo[j-1];
        end

        assign n_s0 = sqrt_step(rem_in, root_in, rad_in[2*(32-2*j) +: 2]);

        if (2*j + 1 <= 32) begin : g_two
            assign n_s1 = sqrt_step(n_s0.rem, n_s0.root, rad_in[2*(31-2*j) +: 2]);
        end else begin : g_one
            assign n_s1 = n_s0;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[j]  <= rad_in;
                r_rem[j]  <= n_s1.rem;
                r_root[j] <= n_s1.root;
                r_geo[j]  <= geo_in;
            end
        end
    end

    assign o_valid = r_v[SQ_STAGES-1];
    assign o_root  = r_root[SQ_STAGES-1];
    assign o_geo   = r_geo[SQ_STAGES-1];

endmodule

>>> rtl/core/sckg_kernel.sv
// Kernel polynomial stages: q, t and s powers, weight and gradient magnitude.
// Depends on sckg_pkg; reads the configuration registers held at the top level.
module sckg_kernel (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  sckg_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    input  logic [32:0]    i_r,
    input  sckg_pkg::t_geo i_geo,
    output logic           o_valid,
    output sckg_pkg::t_kern o_kern
);
    import sckg_pkg::*;

    // stage 1: q partial products
    logic        r_v1;
    t_geo        r_geo1;
    logic [32:0] r_r1;
    logic [63:0] r_pl1;
    logic [31:0] r_ph1;
    // stage 2: q, support, t, s
    logic          r_v2;
    t_geo          r_geo2;
    logic [32:0]   r_r2;
    logic          r_sup2;
    logic          r_lt2;
    logic [TW-1:0] r_t2;
    logic [SW-1:0] r_s2;
    // stage 3: squares
    logic           r_v3;
    t_geo           r_geo3;
    logic [32:0]    r_r3;
    logic           r_sup3;
    logic           r_lt3;
    logic [TW-1:0]  r_t3;
    logic [SW-1:0]  r_s3;
    logic [T2W-1:0] r_tt3;
    logic [S2W-1:0] r_ss3;
    // stage 4: cubes
    logic           r_v4;
    t_geo           r_geo4;
    logic [32:0]    r_r4;
    logic           r_sup4;
    logic           r_lt4;
    logic [T2W-1:0] r_tt4;
    logic [S2W-1:0] r_ss4;
    logic [T3W-1:0] r_ttt4;
    logic [S3W-1:0] r_sss4;
    // stage 5: polynomials
    logic          r_v5;
    t_geo          r_geo5;
    logic [32:0]   r_r5;
    logic          r_sup5;
    logic [PW-1:0] r_p5;
    logic [AW-1:0] r_ag5;
    logic          r_gneg5;
    // stage 6: scaling products
    logic             r_v6;
    t_geo             r_geo6;
    logic [32:0]      r_r6;
    logic             r_sup6;
    logic             r_gneg6;
    logic [32+PW-1:0] r_wp6;
    logic [32+AW-1:0] r_mp6;
    // stage 7: weight saturated, magnitude partial products
    logic        r_v7;
    t_geo        r_geo7;
    logic [32:0] r_r7;
    logic        r_sup7;
    logic        r_gneg7;
    logic [31:0] r_w7;
    logic        r_wsat7;
    logic [63:0] r_mlo7;
    logic [35:0] r_mhi7;
    // stage 8
    logic  r_v8;
    t_kern r_k8;

    logic [64:0]     n_q;
    logic [2*TW-1:0] n_tt;
    logic [2*SW-1:0] n_ss;
    logic [T2W+TW-1:0] n_ttt;
    logic [S2W+SW-1:0] n_sss;
    logic [T3W-1:0]  n_sub;
    logic [PW-1:0]   n_p;
    logic [AW-1:0]   n_a3;
    logic [AW-1:0]   n_b12;
    logic            n_gneg;
    logic [AW-1:0]   n_ag;
    logic [35:0]     n_w36;
    logic [35:0]     n_m36;
    logic [MAGW-1:0] n_mag;

    always_comb begin
        n_q  = 65'({r_ph1, {FRAC{1'b0}}}) + 65'(r_pl1[63:FRAC]);
        n_tt = (2*TW)'(r_t2) * (2*TW)'(r_t2);
        n_ss = (2*SW)'(r_s2) * (2*SW)'(r_s2);
        n_ttt = (T2W+TW)'(r_tt3) * (T2W+TW)'(r_t3);
        n_sss = (S2W+SW)'(r_ss3) * (S2W+SW)'(r_s3);

        // clip a polynomial made negative by truncation
        n_sub = r_lt4 ? {1'b0, r_sss4, 2'b00} : '0;
        n_p   = (n_sub > r_ttt4) ? '0 : r_ttt4 - n_sub;
        n_a3  = {1'b0, r_tt4} + {r_tt4, 1'b0};
        n_b12 = r_lt4 ? ({r_ss4, 3'b000} + {1'b0, r_ss4, 2'b00}) : '0;
        n_gneg = n_a3 > n_b12;
        n_ag   = n_gneg ? n_a3 - n_b12 : n_b12 - n_a3;

        n_w36 = r_wp6[32+PW-1:FRAC];
        n_m36 = r_mp6[32+AW-1:FRAC];
        n_mag = 65'({r_mhi7, {FRAC{1'b0}}}) + 65'(r_mlo7[63:FRAC]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_geo1 <= i_geo;
            r_r1   <= i_r;
            r_pl1  <= 64'(i_r[31:0]) * 64'(i_cfg.inv);
            r_ph1  <= i_r[32] ? i_cfg.inv : '0;

            r_geo2 <= r_geo1;
            r_r2   <= r_r1;
            r_sup2 <= n_q < TWO_Q;
            r_lt2  <= n_q < ONE_Q;
            r_t2   <= TWO_Q[TW-1:0] - n_q[TW-1:0];
            r_s2   <= ONE_Q[SW-1:0] - n_q[SW-1:0];

            r_geo3 <= r_geo2;
            r_r3   <= r_r2;
            r_sup3 <= r_sup2;
            r_lt3  <= r_lt2;
            r_t3   <= r_t2;
            r_s3   <= r_s2;
            r_tt3  <= n_tt[FRAC +: T2W];
            r_ss3  <= n_ss[FRAC +: S2W];

            r_geo4 <= r_geo3;
            r_r4   <= r_r3;
            r_sup4 <= r_sup3;
            r_lt4  <= r_lt3;
            r_tt4  <= r_tt3;
            r_ss4  <= r_ss3;
            r_ttt4 <= n_ttt[FRAC +: T3W];
            r_sss4 <= n_sss[FRAC +: S3W];

            r_geo5  <= r_geo4;
            r_r5    <= r_r4;
            r_sup5  <= r_sup4;
            r_p5    <= r_sup4 ? n_p : '0;
            r_ag5   <= r_sup4 ? n_ag : '0;
            r_gneg5 <= r_sup4 & n_gneg;

            r_geo6  <= r_geo5;
            r_r6    <= r_r5;
            r_sup6  <= r_sup5;
            r_gneg6 <= r_gneg5;
            r_wp6   <= (32+PW)'(i_cfg.alpha) * (32+PW)'(r_p5);
            r_mp6   <= (32+AW)'(i_cfg.alpha) * (32+AW)'(r_ag5);

            r_geo7  <= r_geo6;
            r_r7    <= r_r6;
            r_sup7  <= r_sup6;
            r_gneg7 <= r_gneg6;
            r_wsat7 <= |n_w36[35:31];
            r_w7    <= (|n_w36[35:31]) ? 32'h7FFF_FFFF : n_w36[31:0];
            r_mlo7  <= 64'(n_m36[31:0]) * 64'(i_cfg.inv);
            r_mhi7  <= 36'(n_m36[35:32]) * 36'(i_cfg.inv);

            r_k8.geo     <= r_geo7;
            r_k8.r       <= r_r7;
            r_k8.support <= r_sup7;
            r_k8.w       <= r_w7;
            r_k8.w_sat   <= r_wsat7;
            r_k8.mag     <= n_mag;
            r_k8.gneg    <= r_gneg7;
        end
    end

    assign o_valid = r_v8;
    assign o_kern  = r_k8;

endmodule

>>> rtl/core/sckg_div.sv
// Pipelined restoring divider for both axes: u = floor(|d| * 2^32 / r).
// Depends on sckg_pkg; the kernel results travel alongside.
module sckg_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  sckg_pkg::t_kern i_kern,
    output logic            o_valid,
    output sckg_pkg::t_divo o_res
);
    import sckg_pkg::*;

    logic        r_v    [DIV_STAGES];
    t_kern       r_k    [DIV_STAGES];
    logic [33:0] r_remx [DIV_STAGES];
    logic [33:0] r_remy [DIV_STAGES];
    logic [32:0] r_ux   [DIV_STAGES];
    logic [32:0] r_uy   [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_st
        logic        v_in;
        t_kern       k_in;
        logic [33:0] remx_in;
        logic [33:0] remy_in;
        logic [32:0] ux_in;
        logic [32:0] uy_in;
        t_dv         n_x0;
        t_dv         n_y0;
        t_dv         n_x1;
        t_dv         n_y1;

        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign k_in    = i_kern;
            assign remx_in = {2'b00, i_kern.geo.adx};
            assign remy_in = {2'b00, i_kern.geo.ady};
            assign ux_in   = '0;
            assign uy_in   = '0;
        end else begin : g_next
            assign v_in    = r_v[j-1];
            assign k_in    = r_k[j-1];
            assign remx_in = r_remx[j-1];
            assign remy_in = r_remy[j-1];
            assign ux_in   = r_ux[j-1];
            assign uy_in   = r_uy[j-1];
        end

        // the first quotient bit compares without a shift
        assign n_x0 = div_step(remx_in, k_in.r, 1'(j != 0), ux_in);
        assign n_y0 = div_step(remy_in, k_in.r, 1'(j != 0), uy_in);

        if (2*j + 1 <= 32) begin : g_two
            assign n_x1 = div_step(n_x0.rem, k_in.r, 1'b1, n_x0.quo);
            assign n_y1 = div_step(n_y0.rem, k_in.r, 1'b1, n_y0.quo);
        end else begin : g_one
            assign n_x1 = n_x0;
            assign n_y1 = n_y0;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_k[j]    <= k_in;
                r_remx[j] <= n_x1.rem;
                r_remy[j] <= n_y1.rem;
                r_ux[j]   <= n_x1.quo;
                r_uy[j]   <= n_y1.quo;
            end
        end
    end

    assign o_valid  = r_v[DIV_STAGES-1];
    assign o_res.k  = r_k[DIV_STAGES-1];
    assign o_res.ux = r_ux[DIV_STAGES-1];
    assign o_res.uy = r_uy[DIV_STAGES-1];

endmodule

>>> tb/tb_sph_cubic_kernel_and_gradient.sv
// Testbench for the SPH cubic spline kernel and gradient pipeline.
// Drives particle pairs and APB writes, predicts each result and checks it; needs sckg_pkg.
`timescale 1ns / 100ps

module tb_sph_cubic_kernel_and_gradient;
    import sckg_pkg::*;

    typedef struct packed {
        logic        sat;
        logic        sup;
        logic [31:0] gy;
        logic [31:0] gx;
        logic [31:0] w;
    } t_kres;

    localparam int CYCLE_LIMIT = 900000;
    localparam int LATENCY     = 46;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [127:0] i_s_tdata = '0;   // point_a_x, point_a_y, point_b_x, point_b_y
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [103:0] o_m_tdata;        // weight, gradient_x, gradient_y, in_support, saturated
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    logic [63:0] inv_len = 64'd65536;
    logic [63:0] alpha   = 64'd26075;
    t_kres       kern_queue[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          hold_off = 0;
    bit          rx_random = 1'b0;

    sph_cubic_kernel_and_gradient uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [63:0] root65(logic carry, logic [63:0] lo);
        logic [67:0] rem;
        logic [67:0] trial;
        logic [63:0] root;
        logic [1:0]  pr;
        rem  = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            pr    = (i == 32) ? {1'b0, carry} : lo[2*i +: 2];
            rem   = {rem[65:0], pr};
            trial = {2'b0, root, 2'b01};
            root  = root << 1;
            if (rem >= trial) begin
                rem     = rem - trial;
                root[0] = 1'b1;
            end
        end
        return root;
    endfunction

    function automatic logic [63:0] mul_frac(logic [63:0] a, logic [63:0] b);
        return (((a >> 32) * b) << (32 - FRAC)) + (((a & 64'hFFFF_FFFF) * b) >> FRAC);
    endfunction

    function automatic logic [31:0] clip32(longint v, ref logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] axis_grad(logic [63:0] mag, longint d, logic [63:0] r,
                                              logic gneg, ref logic flag);
        logic [63:0] ad;
        logic [63:0] u;
        logic [63:0] c;
        logic        ng;
        if (d == 0) return 32'd0;
        ad = (d < 0) ? -d : d;
        u  = (ad << 32) / r;
        c  = (mag >> 32) * u + (((mag & 64'hFFFF_FFFF) * u) >> 32);
        ng = (d < 0) != gneg;
        return clip32(ng ? -longint'(c) : longint'(c), flag);
    endfunction

    function automatic t_kres kernel_of(logic [127:0] pair);
        t_kres       res;
        longint      dx;
        longint      dy;
        longint      p;
        longint      g;
        logic [63:0] adx, ady, sx, sum, r, q, t, t2, t3, s, s2, s3, ag, mag;
        logic        flag;
        dx   = longint'($signed(pair[31:0])) - longint'($signed(pair[95:64]));
        dy   = longint'($signed(pair[63:32])) - longint'($signed(pair[127:96]));
        adx  = (dx < 0) ? -dx : dx;
        ady  = (dy < 0) ? -dy : dy;
        sx   = adx * adx;
        sum  = sx + ady * ady;
        r    = root65(sum < sx, sum);
        q    = mul_frac(r, inv_len);
        res  = '0;
        flag = 1'b0;
        res.sup = q < TWO_Q;
        if (res.sup) begin
            t  = TWO_Q - q;
            t2 = (t * t) >> FRAC;
            t3 = (t2 * t) >> FRAC;
            p  = t3;
            g  = -3 * longint'(t2);
            if (q < ONE_Q) begin
                s  = ONE_Q - q;
                s2 = (s * s) >> FRAC;
                s3 = (s2 * s) >> FRAC;
                p  = p - 4 * longint'(s3);
                g  = g + 12 * longint'(s2);
            end
            if (p < 0) p = 0;
            res.w = clip32(longint'((alpha * p) >> FRAC), flag);
            if (dx != 0 || dy != 0) begin
                ag   = (g < 0) ? -g : g;
                mag  = mul_frac((alpha * ag) >> FRAC, inv_len);
                res.gx = axis_grad(mag, dx, r, g < 0, flag);
                res.gy = axis_grad(mag, dy, r, g < 0, flag);
            end
        end
        res.sat = flag;
        return res;
    endfunction

    task automatic reg_write(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_INV) inv_len = value;
        else alpha = value;
    endtask

    // leave tvalid high after acceptance so back-to-back transactions need no gap
    task automatic send_pair(logic [127:0] pair, bit gaps);
        int gap;
        gap = 0;
        if (gaps)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pair;
        do @(posedge i_clk); while (!o_s_tready);
        kern_queue.push_back(kernel_of(pair));
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (kern_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
            default: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
        endcase
    endfunction

    function automatic logic [127:0] rnd_pair(int mode);
        logic [31:0] ax, ay;
        ax = rnd_coord(0);
        ay = rnd_coord(0);
        if (mode == 0) return {rnd_coord(0), rnd_coord(0), ay, ax};
        return {ay + rnd_coord(mode), ax + rnd_coord(mode), ay, ax};
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_kres got;
        t_kres want;
        if (o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[97:0];
            if (kern_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = kern_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected w %h gx %h gy %h sup %b sat %b",
                                 want.w, want.gx, want.gy, want.sup, want.sat);
                        $display("          got      w %h gx %h gy %h sup %b sat %b",
                                 got.w, got.gx, got.gy, got.sup, got.sat);
                    end
                end
            end
        end
    end

    // receiver: hold off on request, else random stalls with an occasional long one in random mode, else always ready
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off   <= hold_off - 1;
            i_m_tready <= 1'b0;
        end else if (rx_random) begin
            if ($urandom_range(0, 99) == 0) begin
                hold_off   <= $urandom_range(10, 40);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 3) != 0);
            end
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        logic [31:0] mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        send_pair({32'd0, 32'd0, 32'd0, 32'd0}, 0);
        send_pair({mn, mn, mx, mx}, 0);
        send_pair({mx, mx, mn, mn}, 0);
        send_pair({32'd0, 32'd0, 32'h0000_8000, 32'd0}, 0);
        send_pair({32'd0, 32'd0, 32'd0, 32'hFFFF_8000}, 0);
        send_pair({32'd0, 32'd0, 32'h0001_0000, 32'h0000_0000}, 0);
        send_pair({32'd0, 32'd0, 32'h0001_FFFF, 32'd0}, 0);
        send_pair({32'd0, 32'd0, 32'h0002_0000, 32'd0}, 0);
        send_pair({32'd0, 32'd0, 32'h0000_B505, 32'h0000_B505}, 0);
        send_pair({32'd0, 32'd0, 32'd1, 32'd1}, 0);
        send_pair({32'h1234_5678, mn, 32'h1234_5678, mn}, 0);
        drain();
    endtask

    task automatic test_config_extremes();
        reg_write(REG_INV, 32'd1);
        reg_write(REG_SCALE, 32'hFFFF_FFFF);
        for (int i = 0; i < 8; i++) send_pair(rnd_pair(i % 3), 0);
        send_pair({32'd0, 32'd0, 32'd0, 32'd0}, 0);
        drain();
        reg_write(REG_INV, 32'hFFFF_FFFF);
        reg_write(REG_SCALE, 32'd0);
        for (int i = 0; i < 6; i++) send_pair(rnd_pair(2), 0);
        send_pair({32'd0, 32'd0, 32'd1, 32'd0}, 0);
        drain();
        reg_write(REG_INV, 32'h0004_0000);
        reg_write(REG_SCALE, 32'h7FFF_FFFF);
        for (int i = 0; i < 6; i++) send_pair(rnd_pair(2), 0);
        drain();
    endtask

    task automatic test_random(int count);
        rx_random = 1'b1;
        for (int i = 0; i < count; i++) begin
            int m;
            m = $urandom_range(0, 9);
            send_pair(rnd_pair(m < 1 ? 0 : (m < 5 ? 1 : 2)), 1);
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_off = 200;
        for (int i = 0; i < 150; i++) send_pair(rnd_pair(1), 0);
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        reg_write(REG_INV, 32'h0001_0000);
        reg_write(REG_SCALE, 32'd26075);
        test_random(485);
        test_backpressure();
        reg_write(REG_INV, $urandom_range(32'h0000_4000, 32'h0010_0000));
        reg_write(REG_SCALE, $urandom());
        test_random(485);
        rx_random = 1'b0;
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && kern_queue.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sph_cubic_kernel_and_gradient.f
rtl/core/sckg_pkg.sv
rtl/core/sckg_sqrt.sv
rtl/core/sckg_kernel.sv
rtl/core/sckg_div.sv
rtl/core/sph_cubic_kernel_and_gradient.sv
tb/tb_sph_cubic_kernel_and_gradient.sv
